@@ src/pmtb_pkg.sv @@
// ----------------------------------------------------------------------------
// pmtb_pkg: shared types, constants and box arithmetic for the trim-bounds block
// Holds the pixel request record, register codes and the per-axis crop helpers.
// ----------------------------------------------------------------------------
package pmtb_pkg;

  localparam int MAX_DIM = 4096;
  localparam int POS_W   = $clog2(MAX_DIM);
  localparam int DIM_W   = 13;
  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int RGB_W   = 24;

  // Two-entry decoupling queue between front and back
  localparam int QDEPTH  = 2;
  localparam int QPTR_W  = $clog2(QDEPTH);
  localparam int QCNT_W  = $clog2(QDEPTH + 1);

  // Reciprocal constants: exact for the value ranges used below
  localparam int          MUL_W        = 32;
  localparam logic [31:0] DIV3_MUL     = 32'd21846;
  localparam int          DIV3_SHIFT   = 16;
  localparam logic [31:0] DIV100_MUL   = 32'd5243;
  localparam int          DIV100_SHIFT = 19;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [DIM_W-1:0] dim_t;

  typedef enum logic [1:0] {
    REG_FRAME_WIDTH  = 2'd0,
    REG_FRAME_HEIGHT = 2'd1,
    REG_PAPER_RGB    = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic content;
    logic eof;
    pos_t col;
    pos_t row;
  } pix_rec_t;

  typedef struct packed {
    dim_t w;
    dim_t h;
  } dims_t;

  typedef struct packed {
    dim_t lo_cap;
    dim_t hi_floor;
    dim_t grow;
  } axis_lim_t;

  typedef struct packed {
    logic seen;
    pos_t first_col;
    pos_t last_col;
    pos_t first_row;
    pos_t last_row;
  } bounds_t;

  typedef struct packed {
    dim_t low;
    dim_t span;
  } axis_box_t;

  localparam bounds_t BOUNDS_RST = '{
    seen:      1'b0,
    first_col: '1,
    last_col:  '0,
    first_row: '1,
    last_row:  '0
  };

  // Zero acts as one, anything above the maximum acts as the maximum
  function automatic dim_t eff_dim(input dim_t v);
    dim_t r;
    r = v;
    if (v == '0) begin
      r = DIM_W'(1);
    end else if (v > DIM_W'(MAX_DIM)) begin
      r = DIM_W'(MAX_DIM);
    end
    return r;
  endfunction

  // size/3, 2*size/3 and size/100 by reciprocal multiplication
  function automatic axis_lim_t axis_limits(input dim_t size);
    logic [MUL_W-1:0] p_lo;
    logic [MUL_W-1:0] p_hi;
    logic [MUL_W-1:0] p_gr;
    axis_lim_t        lim;
    p_lo = MUL_W'(size) * DIV3_MUL;
    p_hi = MUL_W'({size, 1'b0}) * DIV3_MUL;
    p_gr = MUL_W'(size) * DIV100_MUL;
    lim.lo_cap   = DIM_W'(p_lo >> DIV3_SHIFT);
    lim.hi_floor = DIM_W'(p_hi >> DIV3_SHIFT);
    lim.grow     = DIM_W'(p_gr >> DIV100_SHIFT);
    return lim;
  endfunction

  function automatic axis_box_t axis_bounds(input dim_t size, input axis_lim_t lim,
                                            input logic seen, input pos_t first,
                                            input pos_t last);
    dim_t           low;
    dim_t           high;
    logic [DIM_W:0] high_g;
    axis_box_t      box;
    low  = seen ? DIM_W'(first) : size;
    if (low > lim.lo_cap) begin
      low = lim.lo_cap;
    end
    high = seen ? DIM_W'(last) : lim.hi_floor;
    if (high < lim.hi_floor) begin
      high = lim.hi_floor;
    end
    low    = (low > lim.grow) ? (low - lim.grow) : '0;
    high_g = {1'b0, high} + {1'b0, lim.grow};
    if (high_g > {1'b0, size}) begin
      high_g = {1'b0, size};
    end
    box.low  = low;
    box.span = high_g[DIM_W-1:0] - low;
    return box;
  endfunction

endpackage

@@ src/pmtb_front.sv @@
// ----------------------------------------------------------------------------
// pmtb_front: pixel intake and classification
// Accepts pixels, tags content and raster position, flags the frame end.
// ----------------------------------------------------------------------------
module pmtb_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         restart_i,
  input  pmtb_pkg::dims_t              dims_i,
  input  logic [pmtb_pkg::RGB_W-1:0]   paper_rgb_i,
  input  logic                         in_valid_i,
  input  logic [pmtb_pkg::DATA_W-1:0]  pixel_argb_i,
  input  logic                         q_full_i,
  output logic                         in_stall_o,
  output logic                         push_o,
  output pmtb_pkg::pix_rec_t           rec_o
);
  import pmtb_pkg::*;

  pos_t col_q, col_d;
  pos_t row_q, row_d;
  logic col_last;
  logic row_last;

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  assign col_last = !((DIM_W'(col_q) + DIM_W'(1)) < dims_i.w);
  assign row_last = !((DIM_W'(row_q) + DIM_W'(1)) < dims_i.h);

  always_comb begin
    rec_o.content = (pixel_argb_i[31:24] != 8'h00) &&
                    (pixel_argb_i[RGB_W-1:0] != paper_rgb_i);
    rec_o.eof     = col_last && row_last;
    rec_o.col     = col_q;
    rec_o.row     = row_q;
  end

  always_comb begin
    col_d = col_q;
    row_d = row_q;
    if (restart_i) begin
      col_d = '0;
      row_d = '0;
    end else if (push_o) begin
      if (col_last) begin
        col_d = '0;
        row_d = row_last ? '0 : row_q + POS_W'(1);
      end else begin
        col_d = col_q + POS_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q <= '0;
      row_q <= '0;
    end else begin
      col_q <= col_d;
      row_q <= row_d;
    end
  end

endmodule

@@ src/pmtb_queue.sv @@
// ----------------------------------------------------------------------------
// pmtb_queue: short request queue between front and back
// Lets the intake and the tracker stall independently of each other.
// ----------------------------------------------------------------------------
module pmtb_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               flush_i,
  input  logic               push_i,
  input  pmtb_pkg::pix_rec_t push_rec_i,
  input  logic               pop_i,
  output pmtb_pkg::pix_rec_t head_o,
  output logic               vld_o,
  output logic               full_o
);
  import pmtb_pkg::*;

  pix_rec_t            mem_q [QDEPTH];
  logic [QPTR_W-1:0]   wr_ptr_q, wr_ptr_d;
  logic [QPTR_W-1:0]   rd_ptr_q, rd_ptr_d;
  logic [QCNT_W-1:0]   cnt_q, cnt_d;

  assign vld_o  = (cnt_q != '0);
  assign full_o = (cnt_q == QCNT_W'(QDEPTH));
  assign head_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (flush_i) begin
      wr_ptr_d = '0;
      rd_ptr_d = '0;
      cnt_d    = '0;
    end else begin
      if (push_i) begin
        wr_ptr_d = wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_d = rd_ptr_q + QPTR_W'(1);
      end
      case ({push_i, pop_i})
        2'b10:   cnt_d = cnt_q + QCNT_W'(1);
        2'b01:   cnt_d = cnt_q - QCNT_W'(1);
        default: cnt_d = cnt_q;
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_rec_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

@@ src/pmtb_back.sv @@
// ----------------------------------------------------------------------------
// pmtb_back: content tracker and crop box generator
// Folds classified pixels into the bounds, then builds and holds the box.
// ----------------------------------------------------------------------------
module pmtb_back (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        restart_i,
  input  pmtb_pkg::dims_t             dims_i,
  input  pmtb_pkg::pix_rec_t          head_i,
  input  logic                        vld_i,
  output logic                        pop_o,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [pmtb_pkg::DIM_W-1:0]  crop_left_o,
  output logic [pmtb_pkg::DIM_W-1:0]  crop_top_o,
  output logic [pmtb_pkg::DIM_W-1:0]  crop_width_o,
  output logic [pmtb_pkg::DIM_W-1:0]  crop_height_o
);
  import pmtb_pkg::*;

  axis_lim_t lim_w_q;
  axis_lim_t lim_h_q;
  bounds_t   bnd_q, bnd_d, bnd_nxt;
  bounds_t   box_q;
  logic      box_vld_q, box_vld_d;
  logic      out_vld_q, out_vld_d;
  logic      out_free;
  logic      box_free;
  logic      box_load;
  axis_box_t box_x;
  axis_box_t box_y;

  // Limits follow the frame size; refresh every cycle
  always_ff @(posedge clk_i) begin
    lim_w_q <= axis_limits(dims_i.w);
    lim_h_q <= axis_limits(dims_i.h);
  end

  assign out_free = !out_vld_q || !out_stall_i;
  assign box_free = !box_vld_q || out_free;
  // Hold a frame end until the box stage has room
  assign pop_o    = vld_i && (!head_i.eof || box_free);
  assign box_load = pop_o && head_i.eof;

  always_comb begin
    bnd_nxt = bnd_q;
    if (head_i.content) begin
      if (head_i.col < bnd_q.first_col) begin
        bnd_nxt.first_col = head_i.col;
      end
      if (head_i.col > bnd_q.last_col) begin
        bnd_nxt.last_col = head_i.col;
      end
      if (!bnd_q.seen) begin
        bnd_nxt.first_row = head_i.row;
      end
      bnd_nxt.last_row = head_i.row;
      bnd_nxt.seen     = 1'b1;
    end
  end

  always_comb begin
    bnd_d = bnd_q;
    if (restart_i) begin
      bnd_d = BOUNDS_RST;
    end else if (pop_o) begin
      bnd_d = head_i.eof ? BOUNDS_RST : bnd_nxt;
    end
  end

  always_comb begin
    box_vld_d = box_vld_q;
    out_vld_d = out_vld_q;
    if (out_free) begin
      out_vld_d = box_vld_q;
    end
    if (box_load) begin
      box_vld_d = 1'b1;
    end else if (out_free) begin
      box_vld_d = 1'b0;
    end
  end

  assign box_x = axis_bounds(dims_i.w, lim_w_q, box_q.seen, box_q.first_col, box_q.last_col);
  assign box_y = axis_bounds(dims_i.h, lim_h_q, box_q.seen, box_q.first_row, box_q.last_row);

  always_ff @(posedge clk_i) begin
    if (box_load) begin
      box_q <= bnd_nxt;
    end
    if (out_free && box_vld_q) begin
      crop_left_o   <= box_x.low;
      crop_width_o  <= box_x.span;
      crop_top_o    <= box_y.low;
      crop_height_o <= box_y.span;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bnd_q     <= BOUNDS_RST;
      box_vld_q <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      bnd_q     <= bnd_d;
      box_vld_q <= box_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  assign out_valid_o = out_vld_q;

endmodule

@@ src/page_margin_trim_bounds_top.sv @@
// ----------------------------------------------------------------------------
// page_margin_trim_bounds_top: crop box finder for ARGB page frames
// One pixel is taken every cycle unless stalled; the box for a frame passes
// the queue, the box register and the output register after its last pixel
// is accepted, and stays until taken. The input stalls only when the
// two-entry queue fills behind a stalled output. Any write to a listed
// register restarts the frame; size/3, 2*size/3 and size/100 are registered.
// ----------------------------------------------------------------------------
module page_margin_trim_bounds_top (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [pmtb_pkg::ADDR_W-1:0]         paddr,
  input  logic [pmtb_pkg::DATA_W-1:0]         pwdata,
  output logic [pmtb_pkg::DATA_W-1:0]         prdata,
  output logic                                pready,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [pmtb_pkg::DATA_W-1:0]         pixel_argb_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic [pmtb_pkg::DIM_W-1:0]          crop_left_o,
  output logic [pmtb_pkg::DIM_W-1:0]          crop_top_o,
  output logic [pmtb_pkg::DIM_W-1:0]          crop_width_o,
  output logic [pmtb_pkg::DIM_W-1:0]          crop_height_o
);
  import pmtb_pkg::*;

  dim_t             frame_width_q;
  dim_t             frame_height_q;
  logic [RGB_W-1:0] paper_rgb_q;
  reg_idx_e         reg_idx;
  logic             cfg_wr;
  logic             cfg_restart;
  dims_t            dims;
  logic             push;
  pix_rec_t         push_rec;
  pix_rec_t         head;
  logic             q_vld;
  logic             q_full;
  logic             pop;

  assign pready  = 1'b1;
  assign reg_idx = reg_idx_e'(paddr[3:2]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_restart = 1'b0;
    prdata      = '0;
    unique case (reg_idx)
      REG_FRAME_WIDTH: begin
        cfg_restart = cfg_wr;
        prdata      = DATA_W'(frame_width_q);
      end
      REG_FRAME_HEIGHT: begin
        cfg_restart = cfg_wr;
        prdata      = DATA_W'(frame_height_q);
      end
      REG_PAPER_RGB: begin
        cfg_restart = cfg_wr;
        prdata      = DATA_W'(paper_rgb_q);
      end
      default: begin
        cfg_restart = 1'b0;
        prdata      = '0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      frame_width_q  <= DIM_W'(MAX_DIM);
      frame_height_q <= DIM_W'(MAX_DIM);
      paper_rgb_q    <= '1;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_FRAME_WIDTH:  frame_width_q  <= pwdata[DIM_W-1:0];
        REG_FRAME_HEIGHT: frame_height_q <= pwdata[DIM_W-1:0];
        REG_PAPER_RGB:    paper_rgb_q    <= pwdata[RGB_W-1:0];
        default:          paper_rgb_q    <= paper_rgb_q;
      endcase
    end
  end

  assign dims.w = eff_dim(frame_width_q);
  assign dims.h = eff_dim(frame_height_q);

  pmtb_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .restart_i    (cfg_restart),
    .dims_i       (dims),
    .paper_rgb_i  (paper_rgb_q),
    .in_valid_i   (in_valid_i),
    .pixel_argb_i (pixel_argb_i),
    .q_full_i     (q_full),
    .in_stall_o   (in_stall_o),
    .push_o       (push),
    .rec_o        (push_rec)
  );

  pmtb_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .flush_i    (cfg_restart),
    .push_i     (push),
    .push_rec_i (push_rec),
    .pop_i      (pop),
    .head_o     (head),
    .vld_o      (q_vld),
    .full_o     (q_full)
  );

  pmtb_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .restart_i     (cfg_restart),
    .dims_i        (dims),
    .head_i        (head),
    .vld_i         (q_vld),
    .pop_o         (pop),
    .out_stall_i   (out_stall_i),
    .out_valid_o   (out_valid_o),
    .crop_left_o   (crop_left_o),
    .crop_top_o    (crop_top_o),
    .crop_width_o  (crop_width_o),
    .crop_height_o (crop_height_o)
  );

  // The box never reaches past the frame on either axis
  a_box_in_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (({1'b0, crop_left_o} + {1'b0, crop_width_o}) <= {1'b0, dims.w}) &&
                    (({1'b0, crop_top_o} + {1'b0, crop_height_o}) <= {1'b0, dims.h}))
    else $error("crop box exceeds frame");

  // A write to a listed register leaves the queue empty
  a_restart_flush: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_restart |=> !q_vld)
    else $error("queue not flushed on restart");

  // The request after a frame end starts the next frame at the origin
  a_eof_wrap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (push && push_rec.eof && !cfg_restart) |=>
      (!push || ((push_rec.col == '0) && (push_rec.row == '0))))
    else $error("position not wrapped after frame end");

endmodule
